// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame receiver.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define FFMR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define FFMR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: rtl/core/ffmr_pkg.sv
// ---------------------------------------------------------------------------
// Frame receiver package
// Item types, codes and sizes shared by the frame receiver modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffmr_pkg;

   localparam int unsigned BUFFER_BYTES = 64;
   localparam int unsigned ADDR_W       = $clog2(BUFFER_BYTES);

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 1'd1;
   localparam logic [7:0] SYNC_FIRST_RESET  = 8'd69;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'd82;

   localparam logic REQ_STREAM = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   localparam logic [1:0] KIND_GOOD    = 2'd0;
   localparam logic [1:0] KIND_CKA_BAD = 2'd1;
   localparam logic [1:0] KIND_CKB_BAD = 2'd2;
   localparam logic [1:0] KIND_READ    = 2'd3;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_SYNC2   = 3'd1;
   localparam logic [2:0] PH_ID      = 3'd2;
   localparam logic [2:0] PH_LEN_LO  = 3'd3;
   localparam logic [2:0] PH_LEN_HI  = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_CKA     = 3'd6;
   localparam logic [2:0] PH_CKB     = 3'd7;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
      logic [5:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  message_id;
      logic [15:0] length_field;
      logic        payload_truncated;
      logic [7:0]  read_data;
   } rsp_item_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic         has_result;
      logic         read_hit;
      rsp_item_type rsp;
   } parse_out_type;

endpackage

// File: rtl/core/ffmr_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries stream bytes and read requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ffmr_req_if;
   logic                  valid;
   logic                  ready;
   ffmr_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/ffmr_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries frame results and read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ffmr_rsp_if;
   logic                  valid;
   logic                  ready;
   ffmr_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/fletcher_framed_message_receiver_top.sv
// ---------------------------------------------------------------------------
// Framed message receiver
// Two-byte sync deframer with Fletcher-8 check bytes and a payload store.
// ---------------------------------------------------------------------------
// An accepted item is held in the input register; its result is held in the result register.
// Throughput: one item per cycle unless a stalled result register holds the input register.
// An item with a result waits in the input register only while the result register is full and not taken.
// Reset clears the parser state and both valid flags at once, and loads the sync registers with their reset values.
// The payload store is not cleared; there is no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fletcher_framed_message_receiver_top (
   input  logic                             clock,
   input  logic                             reset,
   ffmr_req_if.sink                         req_chan,
   ffmr_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [ffmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wr_data
);

   logic                    req_v_ff;
   ffmr_pkg::req_item_type  req_ff;
   logic                    rsp_v_ff;
   ffmr_pkg::rsp_item_type  rsp_ff;
   logic                    rd_hit_ff;

   logic [7:0]              sync_first;
   logic [7:0]              sync_second;
   ffmr_pkg::parse_out_type parse_out;
   ffmr_pkg::ram_wr_type    ram_wr;
   logic                    fire;
   logic                    req_accept;
   logic                    rd_en;
   logic [7:0]              ram_rdata;
   logic                    rsp_is_read;
   logic                    rsp_hdr_zero;

   ffmr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .sync_first  (sync_first),
      .sync_second (sync_second)
   );

   ffmr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (req_ff),
      .sync_first  (sync_first),
      .sync_second (sync_second),
      .result      (parse_out),
      .ram_wr      (ram_wr)
   );

   ffmr_ram #(
      .WIDTH (8),
      .DEPTH (ffmr_pkg::BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (ffmr_pkg::ADDR_W'(req_ff.read_index)),
      .rd_data (ram_rdata)
   );

   assign fire       = req_v_ff && (!parse_out.has_result || !rsp_v_ff || rsp_chan.ready);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rd_en      = fire && parse_out.has_result && parse_out.read_hit;

   assign req_chan.ready = !req_v_ff || fire;
   assign rsp_chan.valid = rsp_v_ff;

   always_comb begin
      rsp_chan.payload           = rsp_ff;
      rsp_chan.payload.read_data = rd_hit_ff ? ram_rdata : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            req_v_ff <= 1'b1;
         end else if (fire) begin
            req_v_ff <= 1'b0;
         end
         if (fire && parse_out.has_result) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_chan.payload;
      end
      if (fire && parse_out.has_result) begin
         rsp_ff    <= parse_out.rsp;
         rd_hit_ff <= parse_out.read_hit;
      end
   end

   assign rsp_is_read  = rsp_v_ff && (rsp_ff.result_kind == ffmr_pkg::KIND_READ);
   assign rsp_hdr_zero = (rsp_ff.message_id == 8'd0) && (rsp_ff.length_field == 16'd0);

   `FFMR_ASSERT_ALWAYS(a_reset_empties, reset |=> !req_v_ff && !rsp_v_ff, "valid after reset")
   `FFMR_ASSERT(a_rw_exclusive, !(ram_wr.en && rd_en), "payload store written and read together")
   `FFMR_ASSERT(a_accept_loads, req_accept |=> req_v_ff, "accepted item not held")
   `FFMR_ASSERT(a_read_hdr_zero, rsp_is_read |-> rsp_hdr_zero, "read result carries header fields")

endmodule

// File: rtl/core/ffmr_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffmr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ffmr_csr.sv
// ---------------------------------------------------------------------------
// Frame receiver configuration registers
// Holds the two sync byte values written through the configuration port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffmr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ffmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wr_data,
   output logic [7:0]                       sync_first,
   output logic [7:0]                       sync_second
);

   logic [7:0] sync_first_ff;
   logic [7:0] sync_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= ffmr_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= ffmr_pkg::SYNC_SECOND_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ffmr_pkg::CSR_SYNC_FIRST: begin
               sync_first_ff <= csr_wr_data;
            end
            ffmr_pkg::CSR_SYNC_SECOND: begin
               sync_second_ff <= csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign sync_first  = sync_first_ff;
   assign sync_second = sync_second_ff;

endmodule

// File: rtl/core/ffmr_parser.sv
// ---------------------------------------------------------------------------
// Frame parser
// Frame phase tracking, Fletcher-8 sums and result generation for one item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffmr_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  ffmr_pkg::req_item_type item,
   input  logic [7:0]             sync_first,
   input  logic [7:0]             sync_second,
   output ffmr_pkg::parse_out_type result,
   output ffmr_pkg::ram_wr_type   ram_wr
);

   logic [2:0]  phase_ff,    phase_in;
   logic [7:0]  frame_id_ff, frame_id_in;
   logic [7:0]  sum_a_ff,    sum_a_in;
   logic [7:0]  sum_b_ff,    sum_b_in;
   logic [15:0] exp_len_ff,  exp_len_in;
   logic [15:0] rcv_cnt_ff,  rcv_cnt_in;

   logic [7:0]  rx;
   logic [7:0]  sum_a_add;
   logic [7:0]  sum_b_add;
   logic [15:0] cnt_inc;
   logic [15:0] len_full;
   logic        store_room;
   ffmr_pkg::rsp_item_type frame_rsp;

   assign rx         = item.rx_byte;
   assign sum_a_add  = sum_a_ff + rx;
   assign sum_b_add  = sum_b_ff + sum_a_add;
   assign cnt_inc    = rcv_cnt_ff + 16'd1;
   assign len_full   = {rx, exp_len_ff[7:0]};
   assign store_room = 32'(rcv_cnt_ff) < ffmr_pkg::BUFFER_BYTES;

   always_comb begin
      frame_rsp                   = '0;
      frame_rsp.message_id        = frame_id_ff;
      frame_rsp.length_field      = exp_len_ff;
      frame_rsp.payload_truncated = 32'(exp_len_ff) > ffmr_pkg::BUFFER_BYTES;
   end

   always_comb begin
      phase_in    = phase_ff;
      frame_id_in = frame_id_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      exp_len_in  = exp_len_ff;
      rcv_cnt_in  = rcv_cnt_ff;
      result      = '0;
      ram_wr      = '0;
      if (item.req_type == ffmr_pkg::REQ_READ) begin
         result.has_result      = 1'b1;
         result.read_hit        = 32'(item.read_index) < ffmr_pkg::BUFFER_BYTES;
         result.rsp.result_kind = ffmr_pkg::KIND_READ;
      end else begin
         unique case (phase_ff)
            ffmr_pkg::PH_HUNT: begin
               if (rx == sync_first) begin
                  phase_in = ffmr_pkg::PH_SYNC2;
               end
            end
            ffmr_pkg::PH_SYNC2: begin
               priority if (rx == sync_second) begin
                  phase_in = ffmr_pkg::PH_ID;
               end else if (rx == sync_first) begin
                  phase_in = ffmr_pkg::PH_SYNC2;
               end else begin
                  phase_in = ffmr_pkg::PH_HUNT;
               end
            end
            ffmr_pkg::PH_ID: begin
               frame_id_in = rx;
               sum_a_in    = rx;
               sum_b_in    = rx;
               phase_in    = ffmr_pkg::PH_LEN_LO;
            end
            ffmr_pkg::PH_LEN_LO: begin
               sum_a_in   = sum_a_add;
               sum_b_in   = sum_b_add;
               exp_len_in = {8'd0, rx};
               phase_in   = ffmr_pkg::PH_LEN_HI;
            end
            ffmr_pkg::PH_LEN_HI: begin
               sum_a_in   = sum_a_add;
               sum_b_in   = sum_b_add;
               exp_len_in = len_full;
               rcv_cnt_in = '0;
               phase_in   = (len_full == 16'd0) ? ffmr_pkg::PH_CKA : ffmr_pkg::PH_PAYLOAD;
            end
            ffmr_pkg::PH_PAYLOAD: begin
               sum_a_in    = sum_a_add;
               sum_b_in    = sum_b_add;
               rcv_cnt_in  = cnt_inc;
               ram_wr.en   = fire && store_room;
               ram_wr.addr = ffmr_pkg::ADDR_W'(rcv_cnt_ff);
               ram_wr.data = rx;
               if (cnt_inc == exp_len_ff) begin
                  phase_in = ffmr_pkg::PH_CKA;
               end
            end
            ffmr_pkg::PH_CKA: begin
               if (rx != sum_a_ff) begin
                  result.has_result      = 1'b1;
                  result.rsp             = frame_rsp;
                  result.rsp.result_kind = ffmr_pkg::KIND_CKA_BAD;
                  phase_in = (rx == sync_first) ? ffmr_pkg::PH_SYNC2 : ffmr_pkg::PH_HUNT;
               end else begin
                  phase_in = ffmr_pkg::PH_CKB;
               end
            end
            ffmr_pkg::PH_CKB: begin
               result.has_result      = 1'b1;
               result.rsp             = frame_rsp;
               result.rsp.result_kind = (rx != sum_b_ff) ? ffmr_pkg::KIND_CKB_BAD
                                                         : ffmr_pkg::KIND_GOOD;
               phase_in = ffmr_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ffmr_pkg::PH_HUNT;
         frame_id_ff <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         exp_len_ff  <= '0;
         rcv_cnt_ff  <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         frame_id_ff <= frame_id_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         exp_len_ff  <= exp_len_in;
         rcv_cnt_ff  <= rcv_cnt_in;
      end
   end

endmodule
